@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the window test RTL. Define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, off while reset is high
`define LFW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also active during reset
`define LFW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LFW_ASSERT(label, prop, msg)
`define LFW_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ hw/rtl/lfw_pkg.sv @@
// ----------------------------------------------------------------------------
// lfw_pkg
// Figure kinds, register indexes and control types for the window test.
// ----------------------------------------------------------------------------
package lfw_pkg;

  typedef enum logic [1:0] {
    KIND_POLYGON = 2'd0,
    KIND_PATH    = 2'd1,
    KIND_BOX     = 2'd2,
    KIND_SREF    = 2'd3
  } figure_kind_t;

  typedef enum logic [1:0] {
    REG_LEFT_X   = 2'd0,
    REG_TOP_Y    = 2'd1,
    REG_RIGHT_X  = 2'd2,
    REG_BOTTOM_Y = 2'd3
  } reg_index_t;

  // control bits of one vertex as it sits in the input register
  typedef struct packed {
    figure_kind_t kind;
    logic         last;
    logic         have_prev;
  } item_ctrl_t;

endpackage

@@ hw/rtl/lfw_cfg.sv @@
// ----------------------------------------------------------------------------
// lfw_cfg
// APB register file holding the four exclusive window bounds.
// ----------------------------------------------------------------------------
module lfw_cfg
  import lfw_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int DATA_W      = 32,
  parameter int ADDR_W      = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic signed [COORD_WIDTH-1:0] window_left_x,
  output logic signed [COORD_WIDTH-1:0] window_top_y,
  output logic signed [COORD_WIDTH-1:0] window_right_x,
  output logic signed [COORD_WIDTH-1:0] window_bottom_y
);

  reg_index_t               reg_idx;
  logic [COORD_WIDTH-1:0]   wr_value;

  // byte offset bits below the register stride are ignored
  assign reg_idx  = reg_index_t'(paddr[ADDR_W-1 -: 2]);
  assign wr_value = pwdata[COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left_x   <= '0;
      window_top_y    <= '0;
      window_right_x  <= '0;
      window_bottom_y <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_LEFT_X:   window_left_x   <= wr_value;
        REG_TOP_Y:    window_top_y    <= wr_value;
        REG_RIGHT_X:  window_right_x  <= wr_value;
        REG_BOTTOM_Y: window_bottom_y <= wr_value;
        default:      ;
      endcase
    end
  end

  // reads return the bound sign-extended to the bus width
  always_comb begin
    unique case (reg_idx)
      REG_LEFT_X:   prdata = DATA_W'(window_left_x);
      REG_TOP_Y:    prdata = DATA_W'(window_top_y);
      REG_RIGHT_X:  prdata = DATA_W'(window_right_x);
      REG_BOTTOM_Y: prdata = DATA_W'(window_bottom_y);
      default:      prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/lfw_test.sv @@
// ----------------------------------------------------------------------------
// lfw_test
// Point and segment tests for one vertex against the window. Path segments
// are widened into a rectangle whose four corners are tested.
// ----------------------------------------------------------------------------
module lfw_test
  import lfw_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  item_ctrl_t                    ctrl,
  input  logic signed [COORD_WIDTH-1:0] prev_x,
  input  logic signed [COORD_WIDTH-1:0] prev_y,
  input  logic signed [COORD_WIDTH-1:0] cur_x,
  input  logic signed [COORD_WIDTH-1:0] cur_y,
  input  logic [COORD_WIDTH-2:0]        half_width,
  input  logic signed [COORD_WIDTH-1:0] window_left_x,
  input  logic signed [COORD_WIDTH-1:0] window_top_y,
  input  logic signed [COORD_WIDTH-1:0] window_right_x,
  input  logic signed [COORD_WIDTH-1:0] window_bottom_y,
  output logic                          hit
);

  // one extra bit keeps x +/- w from wrapping
  localparam int EW = COORD_WIDTH + 1;
  typedef logic signed [EW-1:0] ext_t;

  ext_t ax, ay, bx, by, w;
  ext_t wl, wt, wr, wb;
  ext_t x0, x1, y0, y1;
  logic vertical, a_left;
  logic seg_hit, pt_hit;

  function automatic logic pt_in(ext_t x, ext_t y, ext_t l, ext_t t, ext_t r, ext_t b);
    return (x > l) && (x < r) && (y > b) && (y < t);
  endfunction

  assign ax = EW'(prev_x);
  assign ay = EW'(prev_y);
  assign bx = EW'(cur_x);
  assign by = EW'(cur_y);
  assign w  = ext_t'({2'b00, half_width});
  assign wl = EW'(window_left_x);
  assign wt = EW'(window_top_y);
  assign wr = EW'(window_right_x);
  assign wb = EW'(window_bottom_y);

  assign vertical = (prev_x == cur_x);
  assign a_left   = (prev_x < cur_x);

  always_comb begin
    if (vertical) begin
      x0 = ax - w;
      x1 = ax + w;
      y0 = (ay > by) ? ay : by;
      y1 = (ay > by) ? by : ay;
    end else begin
      // horizontal: y offset taken from the left end
      x0 = a_left ? ax : bx;
      x1 = a_left ? bx : ax;
      y0 = (a_left ? ay : by) + w;
      y1 = (a_left ? ay : by) - w;
    end
  end

  assign seg_hit = pt_in(x0, y0, wl, wt, wr, wb) || pt_in(x1, y0, wl, wt, wr, wb) ||
                   pt_in(x1, y1, wl, wt, wr, wb) || pt_in(x0, y1, wl, wt, wr, wb);
  assign pt_hit  = pt_in(bx, by, wl, wt, wr, wb);

  always_comb begin
    case (ctrl.kind)
      KIND_POLYGON, KIND_BOX: hit = !ctrl.last && pt_hit;
      KIND_PATH:              hit = ctrl.have_prev && seg_hit;
      default:                hit = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/layout_figure_window_test.sv @@
// ----------------------------------------------------------------------------
// layout_figure_window_test
// Streams the vertices of a layout figure and reports whether any tested
// point falls strictly inside the configured window.
// ----------------------------------------------------------------------------
//  channel | handshake           | word
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_ready | figure_kind, point_x, point_y, half_width,
//          |                     | last_point (one vertex)
//  out     | out_valid/out_ready | inside_res (one per figure, on last vertex)
//  apb     | psel/penable/pready | window bounds at 4*i (8*i above 32 bits)
//
//  One vertex per cycle sustained while the result is not stalled. A vertex
//  waits in the input register; its tests run in the single adder/compare
//  level before the result register, loaded when the last vertex moves on.
//  Reset clears the window, the held vertex and the hit flag.
//  A stalled result holds a last vertex in the input register and stops the
//  input behind it; other vertices pass while the result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module layout_figure_window_test
  import lfw_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             figure_kind,
  input  logic signed [COORD_WIDTH-1:0]          point_x,
  input  logic signed [COORD_WIDTH-1:0]          point_y,
  input  logic [COORD_WIDTH-2:0]                 half_width,
  input  logic                                   last_point,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   inside_res,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [((COORD_WIDTH > 32) ? 5 : 4)-1:0] paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                                   pready
);

  localparam int DATA_W = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int ADDR_W = (COORD_WIDTH > 32) ? 5 : 4;

  logic signed [COORD_WIDTH-1:0] window_left_x, window_top_y;
  logic signed [COORD_WIDTH-1:0] window_right_x, window_bottom_y;

  // vertex history, tracked at acceptance
  logic signed [COORD_WIDTH-1:0] prev_x, prev_y;
  logic                          have_prev;

  // input register
  logic                          s0_valid;
  item_ctrl_t                    s0_ctrl;
  logic signed [COORD_WIDTH-1:0] s0_x, s0_y, s0_px, s0_py;
  logic [COORD_WIDTH-2:0]        s0_w;

  logic hit_so_far;
  logic item_hit;
  logic s0_fire;
  logic in_fire;

  assign pready = 1'b1;

  lfw_cfg #(
    .COORD_WIDTH (COORD_WIDTH),
    .DATA_W      (DATA_W),
    .ADDR_W      (ADDR_W)
  ) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .window_left_x   (window_left_x),
    .window_top_y    (window_top_y),
    .window_right_x  (window_right_x),
    .window_bottom_y (window_bottom_y)
  );

  lfw_test #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_test (
    .ctrl            (s0_ctrl),
    .prev_x          (s0_px),
    .prev_y          (s0_py),
    .cur_x           (s0_x),
    .cur_y           (s0_y),
    .half_width      (s0_w),
    .window_left_x   (window_left_x),
    .window_top_y    (window_top_y),
    .window_right_x  (window_right_x),
    .window_bottom_y (window_bottom_y),
    .hit             (item_hit)
  );

  // only a last vertex needs the result slot
  assign s0_fire  = s0_valid && (!s0_ctrl.last || !out_valid || out_ready);
  assign in_ready = !s0_valid || s0_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      prev_x     <= '0;
      prev_y     <= '0;
      have_prev  <= 1'b0;
      hit_so_far <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        s0_valid <= 1'b1;
        if (last_point) begin
          prev_x    <= '0;
          prev_y    <= '0;
          have_prev <= 1'b0;
        end else begin
          prev_x    <= point_x;
          prev_y    <= point_y;
          have_prev <= 1'b1;
        end
      end else if (s0_fire) begin
        s0_valid <= 1'b0;
      end

      if (s0_fire && s0_ctrl.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (s0_fire) begin
        if (s0_ctrl.last) begin
          hit_so_far <= 1'b0;
        end else begin
          hit_so_far <= hit_so_far | item_hit;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_ctrl.kind      <= figure_kind_t'(figure_kind);
      s0_ctrl.last      <= last_point;
      s0_ctrl.have_prev <= have_prev;
      s0_x              <= point_x;
      s0_y              <= point_y;
      s0_w              <= half_width;
      s0_px             <= prev_x;
      s0_py             <= prev_y;
    end
    if (s0_fire && s0_ctrl.last) begin
      inside_res <= hit_so_far | item_hit;
    end
  end

  `LFW_ASSERT(a_result_after_last, $rose(out_valid) |-> $past(s0_fire && s0_ctrl.last), "result word without a last vertex")
  `LFW_ASSERT(a_single_vertex_zero, (s0_fire && s0_ctrl.last && !s0_ctrl.have_prev) |=> (out_valid && !inside_res), "single vertex figure reported a hit")
  `LFW_ASSERT_ALWAYS(a_last_clears_prev, (in_valid && in_ready && last_point) |=> !have_prev, "vertex history kept past end of figure")

endmodule
